// File: rtl/core/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, status codes and beat types of the ray/sphere intersector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int OC_W   = CW + 1;
    localparam int A_W    = 2 * CW;
    localparam int H_W    = 2 * CW + 2;
    localparam int C_W    = 2 * CW + 3;
    localparam int N_LIMB = 3;
    localparam int LIMB_W = (2 * CW + 4) / N_LIMB;
    localparam int MAG_W  = N_LIMB * LIMB_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int D_W    = PROD_W + 1;
    localparam int S_W    = MAG_W;
    localparam int NUM_W  = MAG_W + 2;
    localparam int REM_W  = A_W + CW + FB;
    localparam int Q_W    = CW - 1;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_NO_ROOT  = 2'd1,
        ST_NOT_POS  = 2'd2,
        ST_ZERO_DIR = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [Q_W-1:0] radius;
    } t_ray_in;

    typedef struct packed {
        logic           hit;
        logic [Q_W-1:0] distance;
        t_status        status;
        logic           saturated;
    } t_ray_out;

endpackage

`default_nettype wire

// File: rtl/core/rsi_wmul.sv
// ----------------------------------------------------------------------------
// rsi_wmul
// Two-stage unsigned wide multiplier: limb partial products, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_wmul import rsi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MAG_W-1:0]  i_a,
    input  logic [MAG_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [2*LIMB_W-1:0] r_pp [N_LIMB][N_LIMB];
    logic [PROD_W-1:0]   n_p;
    logic [PROD_W-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_LIMB; i++) begin
                for (int j = 0; j < N_LIMB; j++) begin
                    r_pp[i][j] <= i_a[i*LIMB_W +: LIMB_W] * i_b[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < N_LIMB; i++) begin
            for (int j = 0; j < N_LIMB; j++) begin
                n_p = n_p + (PROD_W'(r_pp[i][j]) << ((i + j) * LIMB_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: rtl/core/ray_sphere_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// Pipelined ray/sphere test giving the nearest positive hit distance.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one ray and one
// sphere per beat in signed fixed point. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns one result beat per input beat, in order:
// hit flag, distance, status and saturation flag.
// The path from the accepting edge to o_out_valid runs through 8 stages of
// dot products, wide products and discriminant, one stage per bit of the
// 66-bit square root, two stages for the root numerators and range check,
// and one stage per bit of the 31-bit quotient, then the output register.
// Throughput is one beat per cycle when no stall holds the pipeline; every stage holds one beat.
// When the receiver stalls, the pipeline keeps moving as long as its last
// stage is empty, so bubbles close up and new beats are still taken; once
// the last stage holds a beat behind a full output register, the whole
// pipeline holds and o_in_ready drops. Nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect_top import rsi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ray_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ray_out o_out_data
);

    localparam int TR_W = PROD_W + 2;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  azero;
        logic                  cneg;
    } t_side;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  azero;
        logic                  dneg;
        logic [PROD_W-1:0]     x;
        logic [S_W-1:0]        r;
    } t_sq;

    typedef struct packed {
        logic             pos;
        logic             sat;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } t_lane;

    typedef struct packed {
        logic [A_W-1:0] a;
        logic           azero;
        logic           dneg;
        t_lane [1:0]    ln;
    } t_dv;

    logic w_adv;
    logic w_last_v;

    // input register
    logic    r_v0;
    t_ray_in r_p0;

    // offsets
    logic                   r_v1;
    logic signed [CW-1:0]   r_d  [3];
    logic signed [OC_W-1:0] r_oc [3];
    logic [Q_W-1:0]         r_rad;

    // products
    logic                    r_v2;
    logic signed [A_W-1:0]   r_dd  [3];
    logic signed [2*CW:0]    r_doc [3];
    logic signed [2*CW+1:0]  r_oo  [3];
    logic [2*Q_W-1:0]        r_rr;

    // dot products
    logic                  r_v3;
    logic [A_W-1:0]        r_a;
    logic signed [H_W-1:0] r_h;
    logic signed [C_W-1:0] r_c;

    // magnitudes
    logic             r_v4;
    t_side            r_s4;
    logic [MAG_W-1:0] r_hmag;
    logic [MAG_W-1:0] r_cmag;

    logic              r_v5;
    logic              r_v6;
    t_side             r_s5;
    t_side             r_s6;
    logic [PROD_W-1:0] w_hh;
    logic [PROD_W-1:0] w_ac;

    logic signed [D_W-1:0] n_d;

    t_sq  r_sq  [S_W+1];
    logic r_sqv [S_W+1];

    t_dv  r_dv  [Q_W+2];
    logic r_dvv [Q_W+2];

    logic signed [NUM_W-1:0] n_nh;
    logic signed [NUM_W-1:0] n_near;
    logic signed [NUM_W-1:0] n_far;
    t_dv                     n_dv0;
    t_dv                     n_dv1;

    t_ray_out n_out;
    logic     r_out_valid;
    t_ray_out r_out;

    assign w_last_v    = r_dvv[Q_W+1];
    assign w_adv       = !r_out_valid || i_out_ready || !w_last_v;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p0 <= i_in_data;

            r_d[0]  <= r_p0.dir_x;
            r_d[1]  <= r_p0.dir_y;
            r_d[2]  <= r_p0.dir_z;
            r_oc[0] <= OC_W'(r_p0.origin_x) - OC_W'(r_p0.center_x);
            r_oc[1] <= OC_W'(r_p0.origin_y) - OC_W'(r_p0.center_y);
            r_oc[2] <= OC_W'(r_p0.origin_z) - OC_W'(r_p0.center_z);
            r_rad   <= r_p0.radius;

            for (int i = 0; i < 3; i++) begin
                r_dd[i]  <= r_d[i] * r_d[i];
                r_doc[i] <= r_d[i] * r_oc[i];
                r_oo[i]  <= r_oc[i] * r_oc[i];
            end
            r_rr <= r_rad * r_rad;

            r_a <= $unsigned(r_dd[0]) + $unsigned(r_dd[1]) + $unsigned(r_dd[2]);
            r_h <= H_W'(r_doc[0]) + H_W'(r_doc[1]) + H_W'(r_doc[2]);
            r_c <= C_W'(r_oo[0]) + C_W'(r_oo[1]) + C_W'(r_oo[2])
                   - $signed(C_W'(r_rr));

            r_s4.h     <= r_h;
            r_s4.a     <= r_a;
            r_s4.azero <= (r_a == '0);
            r_s4.cneg  <= r_c[C_W-1];
            r_hmag     <= MAG_W'($unsigned(r_h[H_W-1] ? -r_h : r_h));
            r_cmag     <= MAG_W'($unsigned(r_c[C_W-1] ? -r_c : r_c));

            r_s5 <= r_s4;
            r_s6 <= r_s5;
        end
    end

    rsi_wmul u_mul_hh (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_hmag),
        .i_b   (r_hmag),
        .o_p   (w_hh)
    );

    rsi_wmul u_mul_ac (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (MAG_W'(r_s4.a)),
        .i_b   (r_cmag),
        .o_p   (w_ac)
    );

    // discriminant
    always_comb begin
        if (r_s6.cneg) begin
            n_d = $signed(D_W'(w_hh) + D_W'(w_ac));
        end else begin
            n_d = $signed(D_W'(w_hh) - D_W'(w_ac));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv[0] <= 1'b0;
        end else if (w_adv) begin
            r_sqv[0] <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq[0].h     <= r_s6.h;
            r_sq[0].a     <= r_s6.a;
            r_sq[0].azero <= r_s6.azero;
            r_sq[0].dneg  <= n_d[D_W-1];
            r_sq[0].x     <= n_d[PROD_W-1:0];
            r_sq[0].r     <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar gi = 0; gi < S_W; gi++) begin : g_sqrt
        localparam int K = S_W - 1 - gi;
        logic [TR_W-1:0] w_trial;
        t_sq             n_sq;

        always_comb begin
            w_trial = (TR_W'(r_sq[gi].r) << (K + 1)) | (TR_W'(1) << (2 * K));
            n_sq    = r_sq[gi];
            if (TR_W'(r_sq[gi].x) >= w_trial) begin
                n_sq.x    = r_sq[gi].x - w_trial[PROD_W-1:0];
                n_sq.r[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqv[gi+1] <= 1'b0;
            end else if (w_adv) begin
                r_sqv[gi+1] <= r_sqv[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[gi+1] <= n_sq;
            end
        end
    end

    // root numerators and range check
    always_comb begin
        n_nh   = -NUM_W'(r_sq[S_W].h);
        n_near = n_nh - $signed(NUM_W'(r_sq[S_W].r));
        n_far  = n_nh + $signed(NUM_W'(r_sq[S_W].r));

        n_dv0.a         = r_sq[S_W].a;
        n_dv0.azero     = r_sq[S_W].azero;
        n_dv0.dneg      = r_sq[S_W].dneg;
        n_dv0.ln[0].pos = !n_near[NUM_W-1] && (n_near != '0);
        n_dv0.ln[0].sat = 1'b0;
        n_dv0.ln[0].rem = REM_W'($unsigned(n_near)) << FB;
        n_dv0.ln[0].q   = '0;
        n_dv0.ln[1].pos = !n_far[NUM_W-1] && (n_far != '0);
        n_dv0.ln[1].sat = 1'b0;
        n_dv0.ln[1].rem = REM_W'($unsigned(n_far)) << FB;
        n_dv0.ln[1].q   = '0;

        n_dv1 = r_dv[0];
        for (int l = 0; l < 2; l++) begin
            n_dv1.ln[l].sat = (r_dv[0].ln[l].rem >= (REM_W'(r_dv[0].a) << Q_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
            r_dvv[1] <= 1'b0;
        end else if (w_adv) begin
            r_dvv[0] <= r_sqv[S_W];
            r_dvv[1] <= r_dvv[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0] <= n_dv0;
            r_dv[1] <= n_dv1;
        end
    end

    // quotient, one bit per stage, near and far lanes side by side
    for (genvar gi = 0; gi < Q_W; gi++) begin : g_div
        localparam int K = Q_W - 1 - gi;
        logic [REM_W-1:0] w_dvs;
        t_dv              n_dv;

        always_comb begin
            w_dvs = REM_W'(r_dv[gi+1].a) << K;
            n_dv  = r_dv[gi+1];
            for (int l = 0; l < 2; l++) begin
                if (!r_dv[gi+1].ln[l].sat && (r_dv[gi+1].ln[l].rem >= w_dvs)) begin
                    n_dv.ln[l].rem  = r_dv[gi+1].ln[l].rem - w_dvs;
                    n_dv.ln[l].q[K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[gi+2] <= 1'b0;
            end else if (w_adv) begin
                r_dvv[gi+2] <= r_dvv[gi+1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[gi+2] <= n_dv;
            end
        end
    end

    // pick the nearest usable root
    always_comb begin
        n_out.hit       = 1'b0;
        n_out.distance  = '0;
        n_out.status    = ST_NOT_POS;
        n_out.saturated = 1'b0;
        if (r_dv[Q_W+1].azero) begin
            n_out.status = ST_ZERO_DIR;
        end else if (r_dv[Q_W+1].dneg) begin
            n_out.status = ST_NO_ROOT;
        end else begin
            for (int l = 1; l >= 0; l--) begin
                if (r_dv[Q_W+1].ln[l].pos
                    && (r_dv[Q_W+1].ln[l].sat || (r_dv[Q_W+1].ln[l].q != '0))) begin
                    n_out.hit       = 1'b1;
                    n_out.status    = ST_HIT;
                    n_out.saturated = r_dv[Q_W+1].ln[l].sat;
                    n_out.distance  = r_dv[Q_W+1].ln[l].sat ? '1 : r_dv[Q_W+1].ln[l].q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_last_v) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last_v) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
